FILE: design/lpkt_pkg.sv
// types and constants shared by the linear probing key table
`default_nettype none

package lpkt_pkg;

  localparam int unsigned KeyW       = 64;
  localparam int unsigned HandleW    = 32;
  localparam int unsigned SlotOutW   = 6;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned RelW       = 7;
  localparam int unsigned HashCntW   = 2;
  localparam int unsigned FoldW      = 23;
  localparam int unsigned RecipShift = 32;

  localparam logic [1:0] CmdLookup = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  localparam logic [2:0] StHit       = 3'd0;
  localparam logic [2:0] StMiss      = 3'd1;
  localparam logic [2:0] StInserted  = 3'd2;
  localparam logic [2:0] StDuplicate = 3'd3;
  localparam logic [2:0] StFull      = 3'd4;
  localparam logic [2:0] StClear     = 3'd5;

  typedef struct packed {
    logic [1:0]         command;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HandleW-1:0]  found_handle;
    logic [SlotOutW-1:0] slot_index;
    logic                handle_valid;
    logic                last;
  } res_t;

  typedef struct packed {
    logic               occ;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

`default_nettype wire

FILE: design/lpkt_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module lpkt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/linear_probe_key_table_core.sv
// linear probing key table: open addressed key store with lookup, insert and clear
//
//   channel   ports                     handshake
//   request   req_i                     start_i while busy_o low
//   result    res_o                     res_valid_o, one cycle, no back pressure
//
// lookup and insert do one ram read per probe;
// a slot count that is not a power of two adds a home reduction step.
// clear sweeps slots one per cycle up to the last slot or MaxResults entries.
// after reset the ram is swept once to empty it, with busy_o high.
// results are a single registered strobe; the receiver cannot stall them.
`default_nettype none

module linear_probe_key_table_core #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire lpkt_pkg::req_t req_i,
  output logic               res_valid_o,
  output lpkt_pkg::res_t     res_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LastSlot = AW'(SLOTS - 1);
  localparam bit IsPow2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam int unsigned ProdW = lpkt_pkg::FoldW + lpkt_pkg::RecipShift;
  localparam logic [31:0] RecipM = 32'((64'd1 << lpkt_pkg::RecipShift) / SLOTS);

  typedef enum logic [5:0] {
    StateInit  = 6'b000001,
    StateIdle  = 6'b000010,
    StateHash  = 6'b000100,
    StateProbe = 6'b001000,
    StateScan  = 6'b010000,
    StateFlush = 6'b100000
  } state_e;

  state_e state_q, state_d;
  lpkt_pkg::req_t req_q, req_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [lpkt_pkg::RelW-1:0] rel_q, rel_d;
  logic [lpkt_pkg::HashCntW-1:0] hcnt_q, hcnt_d;
  logic [lpkt_pkg::FoldW-1:0] fold_q, fold_d;
  logic [lpkt_pkg::FoldW-1:0] quot_q, quot_d;
  logic pend_valid_q, pend_valid_d;
  logic [lpkt_pkg::HandleW-1:0] pend_handle_q, pend_handle_d;
  logic [AW-1:0] pend_slot_q, pend_slot_d;
  logic res_valid_q, res_valid_d;
  lpkt_pkg::res_t res_q, res_d;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  lpkt_pkg::entry_t ram_wdata, ram_rdata;

  logic [AW-1:0] cur_next;
  logic [lpkt_pkg::FoldW-1:0] fold_sum;
  logic [ProdW-1:0] recip_prod;
  logic [lpkt_pkg::FoldW-1:0] fold_rem;
  logic [lpkt_pkg::FoldW-1:0] fold_red;
  logic [AW-1:0] fold_home;

  function automatic logic [lpkt_pkg::SlotOutW-1:0] slot_out(logic [AW-1:0] s);
    logic [AW+lpkt_pkg::SlotOutW-1:0] w;
    w = {{lpkt_pkg::SlotOutW{1'b0}}, s};
    return w[lpkt_pkg::SlotOutW-1:0];
  endfunction

  lpkt_ram #(
    .WIDTH($bits(lpkt_pkg::entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cur_next = (cur_q == LastSlot) ? '0 : cur_q + AW'(1);

  // byte fold with the residue of each byte weight
  always_comb begin
    logic [lpkt_pkg::FoldW-1:0] acc;
    acc = '0;
    for (int b = 0; b < int'(lpkt_pkg::KeyW / 8); b++) begin
      acc = acc + lpkt_pkg::FoldW'(req_q.key[8*b +: 8]) *
                  lpkt_pkg::FoldW'((64'd1 << (8*b)) % SLOTS);
    end
    fold_sum = acc;
  end

  // reciprocal quotient is at most one short, one subtract settles it
  assign recip_prod = ProdW'(fold_q) * ProdW'(RecipM);
  assign fold_rem   = fold_q - quot_q * lpkt_pkg::FoldW'(SLOTS);
  assign fold_red   = (fold_rem >= lpkt_pkg::FoldW'(SLOTS)) ?
                      fold_rem - lpkt_pkg::FoldW'(SLOTS) : fold_rem;
  assign fold_home  = fold_red[AW-1:0];

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    rel_d        = rel_q;
    hcnt_d       = hcnt_q;
    fold_d       = fold_q;
    quot_d       = quot_q;
    pend_valid_d = pend_valid_q;
    pend_handle_d = pend_handle_q;
    pend_slot_d  = pend_slot_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = cur_q;

    case (state_q)
      StateInit: begin
        ram_we = 1'b1;
        if (cur_q == LastSlot) begin
          state_d = StateIdle;
        end else begin
          cur_d = cur_next;
        end
      end

      StateIdle: begin
        if (start_i) begin
          req_d = req_i;
          case (req_i.command)
            lpkt_pkg::CmdLookup, lpkt_pkg::CmdInsert: begin
              cnt_d = '0;
              if (IsPow2) begin
                cur_d     = req_i.key[AW-1:0];
                ram_re    = 1'b1;
                ram_raddr = req_i.key[AW-1:0];
                state_d   = StateProbe;
              end else begin
                hcnt_d  = '0;
                state_d = StateHash;
              end
            end
            lpkt_pkg::CmdClear: begin
              cur_d        = '0;
              rel_d        = '0;
              pend_valid_d = 1'b0;
              ram_re       = 1'b1;
              ram_raddr    = '0;
              state_d      = StateScan;
            end
            default: begin
              res_valid_d = 1'b1;
              res_d = '{status: lpkt_pkg::StMiss, found_handle: '0, slot_index: '0,
                        handle_valid: 1'b0, last: 1'b1};
            end
          endcase
        end
      end

      StateHash: begin
        hcnt_d = hcnt_q + lpkt_pkg::HashCntW'(1);
        if (hcnt_q == '0) begin
          fold_d = fold_sum;
        end else if (hcnt_q == lpkt_pkg::HashCntW'(1)) begin
          quot_d = recip_prod[ProdW-1:lpkt_pkg::RecipShift];
        end else begin
          cur_d     = fold_home;
          ram_re    = 1'b1;
          ram_raddr = fold_home;
          state_d   = StateProbe;
        end
      end

      StateProbe: begin
        if (!ram_rdata.occ) begin
          res_valid_d = 1'b1;
          state_d     = StateIdle;
          if (req_q.command == lpkt_pkg::CmdInsert) begin
            ram_we    = 1'b1;
            ram_wdata = '{occ: 1'b1, key: req_q.key, handle: req_q.handle};
            res_d = '{status: lpkt_pkg::StInserted, found_handle: '0,
                      slot_index: slot_out(cur_q), handle_valid: 1'b0, last: 1'b1};
          end else begin
            res_d = '{status: lpkt_pkg::StMiss, found_handle: '0, slot_index: '0,
                      handle_valid: 1'b0, last: 1'b1};
          end
        end else if (ram_rdata.key == req_q.key) begin
          res_valid_d = 1'b1;
          state_d     = StateIdle;
          if (req_q.command == lpkt_pkg::CmdInsert) begin
            res_d = '{status: lpkt_pkg::StDuplicate, found_handle: '0,
                      slot_index: slot_out(cur_q), handle_valid: 1'b0, last: 1'b1};
          end else begin
            res_d = '{status: lpkt_pkg::StHit, found_handle: ram_rdata.handle,
                      slot_index: slot_out(cur_q), handle_valid: 1'b1, last: 1'b1};
          end
        end else if (cnt_q == LastSlot) begin
          res_valid_d = 1'b1;
          state_d     = StateIdle;
          res_d = '{status: (req_q.command == lpkt_pkg::CmdInsert) ?
                            lpkt_pkg::StFull : lpkt_pkg::StMiss,
                    found_handle: '0, slot_index: '0, handle_valid: 1'b0, last: 1'b1};
        end else begin
          cnt_d     = cnt_q + AW'(1);
          cur_d     = cur_next;
          ram_re    = 1'b1;
          ram_raddr = cur_next;
        end
      end

      StateScan: begin
        if (ram_rdata.occ) begin
          ram_we        = 1'b1;
          ram_wdata     = '{occ: 1'b0, key: ram_rdata.key, handle: ram_rdata.handle};
          rel_d         = rel_q + lpkt_pkg::RelW'(1);
          pend_valid_d  = 1'b1;
          pend_handle_d = ram_rdata.handle;
          pend_slot_d   = cur_q;
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d = '{status: lpkt_pkg::StClear, found_handle: pend_handle_q,
                      slot_index: slot_out(pend_slot_q), handle_valid: 1'b1, last: 1'b0};
          end
        end
        if ((cur_q == LastSlot) ||
            (ram_rdata.occ && rel_q == lpkt_pkg::RelW'(lpkt_pkg::MaxResults - 1))) begin
          state_d = StateFlush;
        end else begin
          cur_d     = cur_next;
          ram_re    = 1'b1;
          ram_raddr = cur_next;
        end
      end

      StateFlush: begin
        res_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
        state_d      = StateIdle;
        if (pend_valid_q) begin
          res_d = '{status: lpkt_pkg::StClear, found_handle: pend_handle_q,
                    slot_index: slot_out(pend_slot_q), handle_valid: 1'b1, last: 1'b1};
        end else begin
          res_d = '{status: lpkt_pkg::StClear, found_handle: '0, slot_index: '0,
                    handle_valid: 1'b0, last: 1'b1};
        end
      end

      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StateInit;
      cur_q        <= '0;
      cnt_q        <= '0;
      rel_q        <= '0;
      hcnt_q       <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      cnt_q        <= cnt_d;
      rel_q        <= rel_d;
      hcnt_q       <= hcnt_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    fold_q        <= fold_d;
    quot_q        <= quot_d;
    pend_handle_q <= pend_handle_d;
    pend_slot_q   <= pend_slot_d;
    res_q         <= res_d;
  end

  assign busy_o      = (state_q != StateIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_hit_carries_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == lpkt_pkg::StHit |-> res_o.handle_valid && res_o.last)
    else $error("hit without handle or not last");

  a_partial_only_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> res_o.status == lpkt_pkg::StClear && busy_o)
    else $error("non-final item outside a clear");

  a_probe_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o &&
    (req_i.command == lpkt_pkg::CmdLookup || req_i.command == lpkt_pkg::CmdInsert)
    |=> busy_o && !res_valid_o)
    else $error("probe finished without reading the ram");

  a_miss_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == lpkt_pkg::StMiss |->
    !res_o.handle_valid && res_o.found_handle == '0 && res_o.slot_index == '0)
    else $error("miss carries data");
`endif

endmodule

`default_nettype wire

FILE: verif/linear_probe_key_table_core_test.sv
// self-checking testbench for the linear probing key table core with a predicting scoreboard
`default_nettype none

module linear_probe_key_table_core_test;

  localparam int unsigned Slots      = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  class key_table_scoreboard;
    logic [lpkt_pkg::KeyW-1:0]    key_tab    [Slots];
    logic [lpkt_pkg::HandleW-1:0] handle_tab [Slots];
    bit                           occ        [Slots];
    int unsigned                  entries;
    int unsigned                  errors;
    lpkt_pkg::res_t               expected_q [$];

    function new();
      entries = 0;
      errors  = 0;
      foreach (occ[i]) occ[i] = 1'b0;
    endfunction

    function void add_result(logic [2:0] status, logic [lpkt_pkg::HandleW-1:0] h,
                             int unsigned slot, bit valid, bit fin);
      lpkt_pkg::res_t r;
      r.status       = status;
      r.found_handle = h;
      r.slot_index   = slot[lpkt_pkg::SlotOutW-1:0];
      r.handle_valid = valid;
      r.last         = fin;
      expected_q.push_back(r);
    endfunction

    // 1 key found, 0 empty slot reached, -1 every slot visited
    function int walk_probe(input logic [lpkt_pkg::KeyW-1:0] k, output int unsigned where);
      int unsigned home, s, i;
      home  = 32'(k % 64'(Slots));
      where = 0;
      for (i = 0; i < Slots; i++) begin
        s = (home + i) % Slots;
        if (!occ[s]) begin
          where = s;
          return 0;
        end
        if (key_tab[s] == k) begin
          where = s;
          return 1;
        end
      end
      return -1;
    endfunction

    function void note_item(lpkt_pkg::req_t r);
      int unsigned where, n;
      int          found;
      case (r.command)
        lpkt_pkg::CmdLookup: begin
          found = walk_probe(r.key, where);
          if (found == 1) add_result(lpkt_pkg::StHit, handle_tab[where], where, 1'b1, 1'b1);
          else add_result(lpkt_pkg::StMiss, '0, 0, 1'b0, 1'b1);
        end
        lpkt_pkg::CmdInsert: begin
          found = walk_probe(r.key, where);
          if (found == 1) begin
            add_result(lpkt_pkg::StDuplicate, '0, where, 1'b0, 1'b1);
          end else if (found == 0) begin
            key_tab[where]    = r.key;
            handle_tab[where] = r.handle;
            occ[where]        = 1'b1;
            entries++;
            add_result(lpkt_pkg::StInserted, '0, where, 1'b0, 1'b1);
          end else begin
            add_result(lpkt_pkg::StFull, '0, 0, 1'b0, 1'b1);
          end
        end
        lpkt_pkg::CmdClear: begin
          n = 0;
          for (where = 0; where < Slots && n < lpkt_pkg::MaxResults; where++) begin
            if (occ[where]) begin
              add_result(lpkt_pkg::StClear, handle_tab[where], where, 1'b1, 1'b0);
              occ[where] = 1'b0;
              entries--;
              n++;
            end
          end
          if (n == 0) add_result(lpkt_pkg::StClear, '0, 0, 1'b0, 1'b1);
          else expected_q[$].last = 1'b1;
        end
        default: add_result(lpkt_pkg::StMiss, '0, 0, 1'b0, 1'b1);
      endcase
    endfunction

    function void check_result(lpkt_pkg::res_t got);
      lpkt_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", got.status, got.slot_index);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.found_handle !== want.found_handle) begin
        $error("found_handle: expected %h, got %h", want.found_handle, got.found_handle);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        errors++;
      end
      if (got.handle_valid !== want.handle_valid) begin
        $error("handle_valid: expected %0d, got %0d", want.handle_valid, got.handle_valid);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  lpkt_pkg::req_t req_i;
  logic           res_valid_o;
  lpkt_pkg::res_t res_o;
  int unsigned    cycles = 0;
  bit             gaps_on;

  key_table_scoreboard sb = new();

  linear_probe_key_table_core #(.SLOTS(Slots)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // results are stable across the low phase
  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  function automatic logic [lpkt_pkg::KeyW-1:0] make_key(int unsigned home);
    logic [lpkt_pkg::KeyW-1:0] k;
    k = {$urandom, $urandom};
    k = k - (k % Slots) + home;
    return k;
  endfunction

  function automatic int unsigned pick_home();
    if ($urandom_range(1)) return $urandom_range(Slots - 1);
    return $urandom_range(Slots - 4, Slots - 1);
  endfunction

  function automatic logic [lpkt_pkg::KeyW-1:0] pick_stored_key();
    int unsigned s;
    if (sb.entries == 0) return {$urandom, $urandom};
    s = $urandom_range(Slots - 1);
    while (!sb.occ[s]) s = $urandom_range(Slots - 1);
    return sb.key_tab[s];
  endfunction

  // called at a rising edge, returns at the edge that takes the item
  task automatic send_item(input logic [1:0] cmd, input logic [lpkt_pkg::KeyW-1:0] k,
                           input logic [lpkt_pkg::HandleW-1:0] h);
    lpkt_pkg::req_t r;
    bit             taken;
    r.command = cmd;
    r.key     = k;
    r.handle  = h;
    if (gaps_on) begin
      while ($urandom_range(99) < 24) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    req_i   <= r;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_item(r);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) send_item(lpkt_pkg::CmdLookup, pick_stored_key(), $urandom);
    else if (pick < 45) send_item(lpkt_pkg::CmdLookup, make_key(pick_home()), $urandom);
    else if (pick < 80) send_item(lpkt_pkg::CmdInsert, make_key(pick_home()), $urandom);
    else if (pick < 88) send_item(lpkt_pkg::CmdInsert, pick_stored_key(), $urandom);
    else if (pick < 95) send_item(lpkt_pkg::CmdClear, {$urandom, $urandom}, $urandom);
    else send_item(CmdUnused, {$urandom, $urandom}, $urandom);
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    gaps_on = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, wraparound, duplicates, unused command, clear
    send_item(lpkt_pkg::CmdLookup, '0, '0);
    send_item(lpkt_pkg::CmdClear, '0, '0);
    send_item(CmdUnused, '1, '1);
    send_item(lpkt_pkg::CmdInsert, '0, '0);
    send_item(lpkt_pkg::CmdInsert, '1, '1);
    send_item(lpkt_pkg::CmdInsert, make_key(Slots - 1), 32'h5a5a_a5a5);
    send_item(lpkt_pkg::CmdLookup, '1, '0);
    send_item(lpkt_pkg::CmdLookup, sb.key_tab[1], '0);
    send_item(lpkt_pkg::CmdInsert, '0, 32'hdead_beef);
    send_item(lpkt_pkg::CmdLookup, '0, '1);
    send_item(lpkt_pkg::CmdLookup, make_key(0), '0);
    send_item(lpkt_pkg::CmdInsert, lpkt_pkg::KeyW'(Slots), 32'h0123_4567);
    send_item(lpkt_pkg::CmdLookup, lpkt_pkg::KeyW'(Slots), '0);
    send_item(CmdUnused, '0, '0);
    send_item(lpkt_pkg::CmdClear, '1, '1);
    send_item(lpkt_pkg::CmdLookup, '0, '0);
    send_item(lpkt_pkg::CmdClear, '0, '0);

    // fill the table completely without idling
    gaps_on = 1'b0;
    while (sb.entries < Slots) begin
      if ($urandom_range(99) < 15) send_item(lpkt_pkg::CmdLookup, pick_stored_key(), $urandom);
      else send_item(lpkt_pkg::CmdInsert, make_key(pick_home()), $urandom);
    end
    gaps_on = 1'b1;
    repeat (3) send_item(lpkt_pkg::CmdInsert, make_key(pick_home()), $urandom);
    send_item(lpkt_pkg::CmdLookup, make_key(pick_home()), $urandom);
    send_item(lpkt_pkg::CmdLookup, pick_stored_key(), $urandom);
    send_item(lpkt_pkg::CmdInsert, pick_stored_key(), $urandom);
    send_item(CmdUnused, make_key(pick_home()), $urandom);
    wait_drained();
    send_item(lpkt_pkg::CmdClear, {$urandom, $urandom}, $urandom);
    send_item(lpkt_pkg::CmdClear, {$urandom, $urandom}, $urandom);

    repeat (60) random_item();
    send_item(lpkt_pkg::CmdClear, '0, '0);

    wait_drained();
    repeat (Slots + 8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
